FILE: sv/lrm_pkg.sv
// ----------------------------------------------------------------------------
// lrm_pkg
// Shared types and constants of the line regex matcher.
// ----------------------------------------------------------------------------
package lrm_pkg;

   localparam int PATTERN_MAX  = 16;
   localparam int POS_W        = $clog2(PATTERN_MAX + 1);
   localparam int SET_W        = PATTERN_MAX + 1;
   localparam int BYTE_W       = 8;
   localparam int LINE_MAX     = 512;
   localparam int KEPT_W       = $clog2(LINE_MAX);
   localparam int LENGTH_W     = 9;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_LSB  = 3;
   localparam int CSR_IDX_W    = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHARS_LOW    = 3'd0,
      REG_CHARS_HIGH   = 3'd1,
      REG_ANY_CHAR     = 3'd2,
      REG_STAR         = 3'd3,
      REG_PATTERN_LEN  = 3'd4,
      REG_ANCHOR_START = 3'd5,
      REG_ANCHOR_END   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W*PATTERN_MAX-1:0] chars;
      logic [PATTERN_MAX-1:0]        any_char_mask;
      logic [PATTERN_MAX-1:0]        star_mask;
      logic [POS_W-1:0]              pattern_length;
      logic                          anchor_start;
      logic                          anchor_end;
   } cfg_type;

   typedef struct packed {
      logic                is_close;
      logic                end_of_input;
      logic [BYTE_W-1:0]   text_byte;
      logic [KEPT_W-1:0]   kept_length;
   } item_type;

endpackage

FILE: sv/line_regex_matcher.sv
// ----------------------------------------------------------------------------
// line_regex_matcher
// Matches newline-terminated lines of a byte stream against a minimal regex.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle unless req_stall is high and gives one verdict
// per closed line (on a newline byte or on end_of_input). A line close is held
// back only while the previous verdict still waits on rsp_stall; a four-entry
// item queue between the byte front end and the NFA lets bytes keep flowing
// meanwhile. Each queued byte is one NFA step through a combinational closure
// and transition unit. The pattern registers are on the APB port at byte address
// 8*index; the user must write them only while no line is in flight (unenforced).
module line_regex_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_line_matched,
   output logic [8:0]  rsp_line_length,
   output logic        rsp_any_matched,
   output logic        rsp_final_line,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import lrm_pkg::*;

   logic [CSR_DATA_W-1:0]  chars_low_ff;
   logic [CSR_DATA_W-1:0]  chars_high_ff;
   logic [PATTERN_MAX-1:0] any_char_ff;
   logic [PATTERN_MAX-1:0] star_ff;
   logic [POS_W-1:0]       pattern_len_ff;
   logic                   anchor_start_ff;
   logic                   anchor_end_ff;

   reg_index_type          csr_index;
   logic                   csr_write;
   cfg_type                cfg;

   logic                   push_valid;
   item_type               push_item;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;
   item_type               q_item;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:CSR_IDX_LSB]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_low_ff    <= '0;
         chars_high_ff   <= '0;
         any_char_ff     <= '0;
         star_ff         <= '0;
         pattern_len_ff  <= '0;
         anchor_start_ff <= 1'b0;
         anchor_end_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CHARS_LOW:    chars_low_ff    <= pwdata;
            REG_CHARS_HIGH:   chars_high_ff   <= pwdata;
            REG_ANY_CHAR:     any_char_ff     <= pwdata[PATTERN_MAX-1:0];
            REG_STAR:         star_ff         <= pwdata[PATTERN_MAX-1:0];
            REG_PATTERN_LEN:  pattern_len_ff  <= pwdata[POS_W-1:0];
            REG_ANCHOR_START: anchor_start_ff <= pwdata[0];
            REG_ANCHOR_END:   anchor_end_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CHARS_LOW:    prdata = chars_low_ff;
         REG_CHARS_HIGH:   prdata = chars_high_ff;
         REG_ANY_CHAR:     prdata = CSR_DATA_W'(any_char_ff);
         REG_STAR:         prdata = CSR_DATA_W'(star_ff);
         REG_PATTERN_LEN:  prdata = CSR_DATA_W'(pattern_len_ff);
         REG_ANCHOR_START: prdata = CSR_DATA_W'(anchor_start_ff);
         REG_ANCHOR_END:   prdata = CSR_DATA_W'(anchor_end_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      cfg.chars          = {chars_high_ff, chars_low_ff};
      cfg.any_char_mask  = any_char_ff;
      cfg.star_mask      = star_ff;
      cfg.pattern_length = pattern_len_ff;
      cfg.anchor_start   = anchor_start_ff;
      cfg.anchor_end     = anchor_end_ff;
   end

   lrm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   lrm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_item   (q_item)
   );

   lrm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_matched (rsp_line_matched),
      .rsp_line_length  (rsp_line_length),
      .rsp_any_matched  (rsp_any_matched),
      .rsp_final_line   (rsp_final_line)
   );

endmodule

FILE: sv/lrm_front.sv
// ----------------------------------------------------------------------------
// lrm_front
// Accepts text bytes, tracks the kept length and end of text of the line,
// and queues matcher steps and line closes.
// ----------------------------------------------------------------------------
module lrm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_text_byte,
   input  logic                    req_end_of_input,
   input  logic                    q_full,
   output logic                    push_valid,
   output lrm_pkg::item_type       push_item
);
   import lrm_pkg::*;

   logic [KEPT_W-1:0] kept_ff, kept_in;
   logic              ended_ff, ended_in;
   logic              accept;
   logic              is_close;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_close  = req_end_of_input || (req_text_byte == NEWLINE_BYTE);

   always_comb begin
      kept_in                = kept_ff;
      ended_in               = ended_ff;
      push_valid             = 1'b0;
      push_item.is_close     = is_close;
      push_item.end_of_input = req_end_of_input;
      push_item.text_byte    = req_text_byte;
      push_item.kept_length  = kept_ff;
      if (accept) begin
         if (is_close) begin
            push_valid = 1'b1;
            kept_in    = '0;
            ended_in   = 1'b0;
         end else if (kept_ff != KEPT_W'(LINE_MAX - 1)) begin
            kept_in = kept_ff + KEPT_W'(1);
            if (!ended_ff) begin
               if (req_text_byte == NUL_BYTE) begin
                  ended_in = 1'b1;
               end else begin
                  push_valid = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff  <= '0;
         ended_ff <= 1'b0;
      end else begin
         kept_ff  <= kept_in;
         ended_ff <= ended_in;
      end
   end

endmodule

FILE: sv/lrm_queue.sv
// ----------------------------------------------------------------------------
// lrm_queue
// Short FIFO of items between the front and the matcher.
// ----------------------------------------------------------------------------
module lrm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  lrm_pkg::item_type       push_item,
   output logic                    full,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output lrm_pkg::item_type       pop_item
);
   import lrm_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/lrm_back.sv
// ----------------------------------------------------------------------------
// lrm_back
// Bit-parallel NFA over pattern positions; gives one verdict per line close.
// ----------------------------------------------------------------------------
module lrm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lrm_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  lrm_pkg::item_type             q_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_line_matched,
   output logic [8:0]                    rsp_line_length,
   output logic                          rsp_any_matched,
   output logic                          rsp_final_line
);
   import lrm_pkg::*;

   // star closure as a parallel prefix: position k+1 inherits k through a star
   function automatic logic [SET_W-1:0] closure(input logic [SET_W-1:0] set,
                                                input logic [PATTERN_MAX-1:0] star,
                                                input logic [POS_W-1:0] len);
      logic [SET_W-1:0] g;
      logic [SET_W-1:0] p;
      g = '0;
      p = '0;
      for (int k = 0; k < SET_W; k++) begin
         g[k] = set[k] && (POS_W'(k) <= len);
      end
      for (int k = 0; k < PATTERN_MAX; k++) begin
         p[k+1] = star[k] && (POS_W'(k) < len);
      end
      for (int s = 0; s < POS_W; s++) begin
         g = g | (p & (g << (1 << s)));
         p = p & (p << (1 << s));
      end
      return g;
   endfunction

   logic [SET_W-1:0]    act_ff, act_in;
   logic                matched_ff, matched_in;
   logic                sticky_ff, sticky_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                hit_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic                final_ff;

   logic [POS_W-1:0]    len;
   logic                out_free;
   logic                do_close;
   logic [SET_W-1:0]    cur;
   logic [SET_W-1:0]    step_set;
   logic [SET_W-1:0]    step_closed;
   logic                at_end;
   logic                hit;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_matched = hit_ff;
   assign rsp_line_length  = length_ff;
   assign rsp_any_matched  = sticky_ff;
   assign rsp_final_line   = final_ff;

   always_comb begin
      len = (cfg.pattern_length > POS_W'(PATTERN_MAX)) ? POS_W'(PATTERN_MAX)
                                                       : cfg.pattern_length;
      out_free = !rsp_valid_ff || !rsp_stall;
      q_pop    = q_valid && (!q_item.is_close || out_free);
      do_close = q_pop && q_item.is_close;

      cur      = closure(act_ff, cfg.star_mask, len);
      step_set = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (cur[i] && (POS_W'(i) < len) &&
             (cfg.any_char_mask[i] || (cfg.chars[BYTE_W*i +: BYTE_W] == q_item.text_byte)))
         begin
            if (cfg.star_mask[i]) begin
               step_set[i] = 1'b1;
            end else begin
               step_set[i+1] = 1'b1;
            end
         end
      end
      if (!cfg.anchor_start) begin
         step_set[0] = 1'b1;
      end
      step_closed = closure(step_set, cfg.star_mask, len);

      at_end = cur[len];
      hit    = (q_item.kept_length != '0) &&
               (cfg.anchor_end ? at_end : (at_end || matched_ff));

      act_in       = act_ff;
      matched_in   = matched_ff;
      sticky_in    = sticky_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (q_pop) begin
         if (q_item.is_close) begin
            act_in       = SET_W'(1);
            matched_in   = 1'b0;
            sticky_in    = sticky_ff || hit;
            rsp_valid_in = 1'b1;
         end else begin
            act_in     = step_set;
            matched_in = matched_ff || cur[len] || step_closed[len];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= SET_W'(1);
         matched_ff   <= 1'b0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         matched_ff   <= matched_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_close) begin
         hit_ff    <= hit;
         length_ff <= LENGTH_W'(q_item.kept_length);
         final_ff  <= q_item.end_of_input;
      end
   end

endmodule
